/* src/l2nv_pkg.sv */
// ----------------------------------------------------------------------------
// l2nv_pkg
// Shared types, register indexes and the reciprocal square root seed table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package l2nv_pkg;

    localparam int SUM_W   = 38;
    localparam int S_W     = 39;
    localparam int LEN_W   = 7;
    localparam int DATA_W  = 16;
    localparam int ADDR_W  = 2;

    localparam logic [ADDR_W-1:0] CFG_EPSILON     = 2'd0;
    localparam logic [ADDR_W-1:0] CFG_QUERY_SCALE = 2'd1;
    localparam logic [ADDR_W-1:0] CFG_VECTOR_LEN  = 2'd2;

    localparam logic [DATA_W-1:0] SCALE_ONE = 16'd4096;

    // One finished vector handed from the front to the back
    typedef struct packed {
        logic [S_W-1:0]    s;
        logic [DATA_W-1:0] scale;
        logic [LEN_W-1:0]  n;
        logic              bank;
    } job_t;

    // Q1.30 seed for rsqrt, indexed by the top three bits of the Q2.30 mantissa
    function automatic logic [31:0] seed_lut(input logic [2:0] idx);
        logic [31:0] r;
        unique case (idx)
            3'd0:    r = 32'd1073741824;
            3'd1:    r = 32'd1073741824;
            3'd2:    r = 32'd960383884;
            3'd3:    r = 32'd811672540;
            3'd4:    r = 32'd715827883;
            3'd5:    r = 32'd647490683;
            3'd6:    r = 32'd595604799;
            default: r = 32'd554477913;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/l2nv_buf.sv */
// ----------------------------------------------------------------------------
// l2nv_buf
// Two-bank element store, one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module l2nv_buf #(
    parameter int AW = 6
) (
    input  wire                          aclk,
    input  wire                          wr_en,
    input  wire  [AW:0]                  wr_addr,
    input  wire  [l2nv_pkg::DATA_W-1:0]  wr_data,
    input  wire  [AW:0]                  rd_addr,
    output logic [l2nv_pkg::DATA_W-1:0]  rd_data
);

    logic [l2nv_pkg::DATA_W-1:0] mem [2**(AW+1)];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* src/l2nv_queue.sv */
// ----------------------------------------------------------------------------
// l2nv_queue
// Two-entry job queue; each entry holds one store bank until the back pops it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module l2nv_queue (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   push,
    input  l2nv_pkg::job_t        push_job,
    output logic                  full,
    input  wire                   pop,
    output logic                  head_valid,
    output l2nv_pkg::job_t        head_job
);

    l2nv_pkg::job_t entry_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_ptr_reg, wr_ptr_reg;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head_job   = entry_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= 2'd0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

/* src/l2nv_front.sv */
// ----------------------------------------------------------------------------
// l2nv_front
// Takes elements, writes them to the store and sums their squares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module l2nv_front #(
    parameter int MAX_LENGTH = 64,
    parameter int AW         = 6
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          in_xfer,
    input  wire  [l2nv_pkg::DATA_W-1:0]  element,
    input  wire                          is_key,
    input  wire  [l2nv_pkg::DATA_W-1:0]  epsilon,
    input  wire  [l2nv_pkg::DATA_W-1:0]  query_scale,
    input  wire  [l2nv_pkg::LEN_W-1:0]   vector_length,
    output logic                         wr_en,
    output logic [AW:0]                  wr_addr,
    output logic                         push,
    output l2nv_pkg::job_t               push_job
);

    logic [l2nv_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [l2nv_pkg::LEN_W-1:0] cnt_reg, n, len;
    logic                       key_reg, key_cur, bank_reg, done;
    logic [16:0]                mag;

    always_comb begin
        mag = element[15] ? 17'(17'h10000 - {1'b0, element}) : {1'b0, element};
        sum_next = l2nv_pkg::SUM_W'(sum_reg + l2nv_pkg::SUM_W'(mag * mag));
        n = cnt_reg + 7'd1;
        if (vector_length == 7'd0) begin
            len = 7'd1;
        end else if (vector_length > 7'(MAX_LENGTH)) begin
            len = 7'(MAX_LENGTH);
        end else begin
            len = vector_length;
        end
        done    = (n >= len);
        key_cur = (cnt_reg == 7'd0) ? is_key : key_reg;
    end

    assign wr_en   = in_xfer;
    assign wr_addr = {bank_reg, cnt_reg[AW-1:0]};
    assign push    = in_xfer && done;

    always_comb begin
        push_job.s     = l2nv_pkg::S_W'(sum_next) + l2nv_pkg::S_W'(epsilon);
        push_job.scale = key_cur ? l2nv_pkg::SCALE_ONE : query_scale;
        push_job.n     = n;
        push_job.bank  = bank_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            cnt_reg  <= '0;
            key_reg  <= 1'b0;
            bank_reg <= 1'b0;
        end else if (in_xfer) begin
            key_reg <= key_cur;
            if (done) begin
                sum_reg  <= '0;
                cnt_reg  <= '0;
                bank_reg <= !bank_reg;
            end else begin
                sum_reg <= sum_next;
                cnt_reg <= n;
            end
        end
    end

endmodule

`default_nettype wire

/* src/l2nv_back.sv */
// ----------------------------------------------------------------------------
// l2nv_back
// Normalizes the sum, runs Newton rsqrt steps, then scales every element.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module l2nv_back #(
    parameter int NEWTON_STEPS = 4,
    parameter int AW           = 6
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          head_valid,
    input  l2nv_pkg::job_t               head_job,
    output logic                         pop,
    output logic [AW:0]                  rd_addr,
    input  wire  [l2nv_pkg::DATA_W-1:0]  rd_data,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [l2nv_pkg::DATA_W-1:0]  out_data,
    output logic                         out_last
);

    localparam int SW = $clog2(NEWTON_STEPS + 1);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_NORM  = 9'b000000010,
        ST_SQ    = 9'b000000100,
        ST_PROD  = 9'b000001000,
        ST_UPD   = 9'b000010000,
        ST_RD    = 9'b000100000,
        ST_MUL1  = 9'b001000000,
        ST_MUL2  = 9'b010000000,
        ST_SHIFT = 9'b100000000
    } state_t;

    state_t                     state_reg, state_next;
    logic [l2nv_pkg::S_W-1:0]   m_reg;
    logic [4:0]                 k_reg;
    logic [31:0]                r_reg, t_reg;
    logic [33:0]                r2_reg;
    logic [SW-1:0]              step_reg;
    logic [l2nv_pkg::LEN_W-1:0] j_reg;
    logic [32:0]                p1_reg;
    logic [63:0]                p2_reg;
    logic                       neg_reg;
    logic                       out_valid_reg;
    logic [l2nv_pkg::DATA_W-1:0] out_data_reg;
    logic                       out_last_reg;

    logic [63:0] sq_full, pr_full, upd_full, rnd, q;
    logic [63:0] pr;
    logic [5:0]  sh;
    logic [16:0] em;
    logic [15:0] y;
    logic        out_free, is_last;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;
    assign rd_addr   = {head_job.bank, j_reg[AW-1:0]};

    always_comb begin
        sq_full  = 64'(r_reg) * 64'(r_reg);
        pr_full  = 64'(m_reg[31:0]) * 64'(r2_reg);
        pr       = pr_full >> 30;
        upd_full = 64'(r_reg) * 64'(t_reg);
        em  = rd_data[15] ? 17'(17'h10000 - {1'b0, rd_data}) : {1'b0, rd_data};
        sh  = 6'd30 + 6'(k_reg);
        rnd = p2_reg + (64'd1 << (sh - 6'd1));
        q   = rnd >> sh;
        if (neg_reg) begin
            y = (q > 64'd32768) ? 16'h8000 : 16'(16'd0 - q[15:0]);
        end else begin
            y = (q > 64'd32767) ? 16'h7FFF : q[15:0];
        end
        out_free = !out_valid_reg || out_ready;
        is_last  = (j_reg + 7'd1 == head_job.n);
        pop      = (state_reg == ST_SHIFT) && out_free && is_last;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (head_valid) begin
                    state_next = (head_job.s == '0) ? ST_RD : ST_NORM;
                end
            end
            ST_NORM: begin
                if (m_reg[38:32] == '0 && m_reg[31:30] != 2'b00) begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:   state_next = ST_PROD;
            ST_PROD: state_next = ST_UPD;
            ST_UPD: begin
                state_next = (step_reg == SW'(NEWTON_STEPS - 1)) ? ST_RD : ST_SQ;
            end
            ST_RD:   state_next = ST_MUL1;
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_SHIFT;
            ST_SHIFT: begin
                if (out_free) begin
                    state_next = is_last ? ST_IDLE : ST_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_SHIFT && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                m_reg    <= head_job.s;
                k_reg    <= 5'd15;
                j_reg    <= '0;
                step_reg <= '0;
                if (head_job.s == '0) begin
                    r_reg <= '0;
                    k_reg <= 5'd0;
                end
            end
            ST_NORM: begin
                if (m_reg[38:32] != '0) begin
                    m_reg <= m_reg >> 2;
                    k_reg <= k_reg + 5'd1;
                end else if (m_reg[31:30] == 2'b00) begin
                    m_reg <= m_reg << 2;
                    k_reg <= k_reg - 5'd1;
                end else begin
                    r_reg <= l2nv_pkg::seed_lut(m_reg[31:29]);
                end
            end
            ST_SQ: r2_reg <= sq_full[63:30];
            ST_PROD: begin
                t_reg <= (pr > 64'h0C0000000) ? 32'd0 : 32'(64'h0C0000000 - pr);
            end
            ST_UPD: begin
                r_reg    <= upd_full[62:31];
                step_reg <= step_reg + SW'(1);
            end
            ST_RD: begin
            end
            ST_MUL1: begin
                p1_reg  <= 33'(em * 33'(head_job.scale));
                neg_reg <= rd_data[15];
            end
            ST_MUL2: p2_reg <= 64'(p1_reg) * 64'(r_reg);
            ST_SHIFT: begin
                if (out_free) begin
                    out_data_reg <= y;
                    out_last_reg <= is_last;
                    j_reg        <= j_reg + 7'd1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/l2_normalize_vector.sv */
// ----------------------------------------------------------------------------
// l2_normalize_vector
// L2 normalization of one Q4.12 vector by rsqrt(sum of squares + epsilon).
// ----------------------------------------------------------------------------
// Elements are taken one per cycle unless the job queue is full, and are
// buffered in one of two store banks while their squares are summed; the
// first element's tuser marks a key (1) or a query (0). After the last
// element the back end normalizes a nonzero sum (two bits per cycle, then
// the seed lookup) and runs NEWTON_STEPS Newton steps (square, product,
// update), then emits the results one at a time through the store read,
// two multiply stages and the output shift. With two banks the next vector
// can stream in while the previous one is emitted.
`timescale 1ns / 1ps
`default_nettype none

module l2_normalize_vector #(
    parameter int MAX_LENGTH   = 64,
    parameter int NEWTON_STEPS = 4
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // element
    input  wire         s_tuser,   // is_key
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // normalized
    output logic        m_tlast,
    input  wire         cfg_we,
    input  wire  [1:0]  cfg_addr,
    input  wire  [15:0] cfg_wdata
);

    localparam int AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;

    logic [15:0] epsilon_reg, scale_reg;
    logic [6:0]  len_reg;

    logic                in_xfer, wr_en, push, full, pop, head_valid;
    logic [AW:0]         wr_addr, rd_addr;
    logic [15:0]         rd_data;
    l2nv_pkg::job_t      push_job, head_job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epsilon_reg <= 16'd1;
            scale_reg   <= 16'd4096;
            len_reg     <= 7'd64;
        end else if (cfg_we) begin
            if (cfg_addr == l2nv_pkg::CFG_EPSILON) begin
                epsilon_reg <= cfg_wdata;
            end else if (cfg_addr == l2nv_pkg::CFG_QUERY_SCALE) begin
                scale_reg <= cfg_wdata;
            end else if (cfg_addr == l2nv_pkg::CFG_VECTOR_LEN) begin
                len_reg <= cfg_wdata[6:0];
            end
        end
    end

    assign s_tready = !full;
    assign in_xfer  = s_tvalid && !full;

    l2nv_front #(.MAX_LENGTH(MAX_LENGTH), .AW(AW)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_xfer       (in_xfer),
        .element       (s_tdata),
        .is_key        (s_tuser),
        .epsilon       (epsilon_reg),
        .query_scale   (scale_reg),
        .vector_length (len_reg),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .push          (push),
        .push_job      (push_job)
    );

    l2nv_buf #(.AW(AW)) u_buf (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_tdata),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    l2nv_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    l2nv_back #(.NEWTON_STEPS(NEWTON_STEPS), .AW(AW)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata),
        .out_last   (m_tlast)
    );

endmodule

`default_nettype wire

/* test/l2_normalize_vector_tb.sv */
// ----------------------------------------------------------------------------
// l2_normalize_vector_tb
// Self-checking bench: random vectors in, normalized elements checked out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module l2_normalize_vector_tb;

    localparam int MAX_LEN = 64;
    localparam int STEPS   = 4;
    localparam int LIMIT   = 2000000;

    typedef struct {
        logic [15:0] normalized;
        logic        last;
    } norm_out_t;

    class norm_scoreboard;
        logic [15:0] buf_elem [MAX_LEN];
        logic [37:0] sq_sum;
        int          count;
        bit          key_vec;
        logic [15:0] eps, qscale;
        logic [6:0]  vlen;
        norm_out_t   pending [$];
        int          mismatches;

        function new();
            sq_sum = '0; count = 0; key_vec = 0;
            eps = 16'd1; qscale = 16'd4096; vlen = 7'd64; mismatches = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                l2nv_pkg::CFG_EPSILON:     eps = val;
                l2nv_pkg::CFG_QUERY_SCALE: qscale = val;
                l2nv_pkg::CFG_VECTOR_LEN:  vlen = val[6:0];
                default: ;
            endcase
        endfunction

        function void note_input(logic [15:0] elem, logic is_key);
            logic [15:0] mag;
            int          lim, n, p, sh, kk;
            logic [63:0] s, m, r, r2, pr, t, em, sc, prod, q;
            norm_out_t   o;
            if (count >= MAX_LEN) count = MAX_LEN - 1;
            if (count == 0) key_vec = is_key;
            buf_elem[count] = elem;
            mag = elem[15] ? -elem : elem;
            sq_sum = sq_sum + 38'(64'(mag) * 64'(mag));
            count++;
            lim = (vlen < 1) ? 1 : (vlen > MAX_LEN ? MAX_LEN : vlen);
            if (count < lim) return;
            n = count;
            s = 64'(sq_sum) + 64'(eps);
            sc = key_vec ? 64'd4096 : 64'(qscale);
            r = 0; kk = 0;
            if (s != 0) begin
                p = 0;
                for (int i = 0; i < 64; i++) if (s[i]) p = i;
                sh = 30 - p;
                if (sh % 2 != 0) sh += 1;
                m = (sh >= 0) ? (s << sh) : (s >> (-sh));
                kk = (30 - sh) / 2;
                r = 64'(l2nv_pkg::seed_lut(m[31:29]));
                for (int i = 0; i < STEPS; i++) begin
                    r2 = (r * r) >> 30;
                    pr = (m * r2) >> 30;
                    t = (pr > (64'd3 << 30)) ? 0 : (64'd3 << 30) - pr;
                    r = (r * t) >> 31;
                end
            end
            for (int j = 0; j < n; j++) begin
                o.normalized = 16'd0;
                if (s != 0) begin
                    em = buf_elem[j][15] ? 64'(17'h10000 - {1'b0, buf_elem[j]})
                                         : 64'(buf_elem[j]);
                    prod = em * sc * r;
                    q = (prod + (64'd1 << (30 + kk - 1))) >> (30 + kk);
                    if (buf_elem[j][15])
                        o.normalized = (q > 32768) ? 16'h8000 : 16'(-q);
                    else
                        o.normalized = (q > 32767) ? 16'h7fff : 16'(q);
                end
                o.last = (j == n - 1);
                pending.push_back(o);
            end
            sq_sum = '0;
            count = 0;
        endfunction

        function void check_result(logic [15:0] data, logic last);
            norm_out_t e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transfer: %h last %b", data, last);
                return;
            end
            e = pending.pop_front();
            if (e.normalized !== data || e.last !== last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp %h/%b got %h/%b", e.normalized, e.last, data, last);
            end
        endfunction
    endclass

    logic        aclk, aresetn;
    logic        s_tvalid, s_tready, s_tuser;
    logic [15:0] s_tdata;
    logic        m_tvalid, m_tready, m_tlast;
    logic [15:0] m_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_wdata;

    norm_scoreboard sb;
    int  send_idle, recv_idle;
    bit  hold_off;
    longint cycles = 0;

    l2_normalize_vector dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        s_tvalid = 0; s_tdata = 0; s_tuser = 0;
        m_tready = 0; cfg_we = 0; cfg_addr = l2nv_pkg::CFG_EPSILON; cfg_wdata = 0;
        aresetn = 0;
        send_idle = 0; recv_idle = 0; hold_off = 0;
        sb = new();
    end

    // receiver and checking
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
            m_tready <= !hold_off && ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 0;
        sb.set_reg(idx, val);
        @(posedge aclk);
    endtask

    task automatic send_elem(logic [15:0] elem, logic is_key);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1; s_tdata <= elem; s_tuser <= is_key;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(elem, is_key);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_elem();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(signed'($urandom_range(8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_vector(int len, bit key);
        for (int i = 0; i < len; i++)
            send_elem(rand_elem(), i == 0 ? key : 1'($urandom_range(1)));
    endtask

    int sent;

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: short vectors, extremes, zero sum, tag taken from first element
        write_reg(l2nv_pkg::CFG_VECTOR_LEN, 16'd4);
        write_reg(l2nv_pkg::CFG_EPSILON, 16'd0);
        send_elem(16'h0000, 1'b0); send_elem(16'h0000, 1'b1);
        send_elem(16'h0000, 1'b0); send_elem(16'h0000, 1'b1);
        send_elem(16'h8000, 1'b1); send_elem(16'h7fff, 1'b0);
        send_elem(16'h0001, 1'b0); send_elem(16'hffff, 1'b0);
        drain();
        write_reg(l2nv_pkg::CFG_VECTOR_LEN, 16'd1);
        write_reg(l2nv_pkg::CFG_QUERY_SCALE, 16'hffff);
        write_reg(l2nv_pkg::CFG_EPSILON, 16'hffff);
        send_elem(16'h8000, 1'b0); send_elem(16'h7fff, 1'b0);
        send_elem(16'h1000, 1'b1); send_elem(16'h0001, 1'b0);
        drain();
        write_reg(l2nv_pkg::CFG_VECTOR_LEN, 16'd0);
        write_reg(l2nv_pkg::CFG_QUERY_SCALE, 16'd0);
        send_elem(16'h4000, 1'b0); send_elem(16'hc000, 1'b1);
        drain();
        write_reg(l2nv_pkg::CFG_VECTOR_LEN, 16'd127);
        write_reg(l2nv_pkg::CFG_QUERY_SCALE, 16'd2048);
        write_reg(l2nv_pkg::CFG_EPSILON, 16'd1);
        send_vector(64, 1'b0);
        drain();

        // random phases with varying settings
        write_reg(l2nv_pkg::CFG_VECTOR_LEN, 16'd3);
        write_reg(l2nv_pkg::CFG_QUERY_SCALE, 16'($urandom));
        send_idle = 28; recv_idle = 51;
        sent = 0;
        while (sent < 12) begin
            send_vector(3, 1'($urandom_range(1)));
            sent += 3;
        end
        // long receiver hold-off while the sender keeps going
        hold_off = 1;
        fork
            begin
                repeat (300) @(posedge aclk);
                hold_off = 0;
            end
            send_vector(9, 1'b0);
        join
        drain();
        write_reg(l2nv_pkg::CFG_VECTOR_LEN, 16'd5);
        write_reg(l2nv_pkg::CFG_EPSILON, 16'($urandom));
        write_reg(l2nv_pkg::CFG_QUERY_SCALE, 16'd4096);
        send_idle = 51; recv_idle = 28;
        sent = 0;
        while (sent < 10) begin
            send_vector(5, 1'($urandom_range(1)));
            sent += 5;
        end
        drain();
        write_reg(l2nv_pkg::CFG_VECTOR_LEN, 16'($urandom_range(2, 8)));
        write_reg(l2nv_pkg::CFG_EPSILON, 16'd0);
        send_idle = 0; recv_idle = 0;
        for (int v = 0; v < 2; v++) send_vector(int'(sb.vlen), 1'($urandom_range(1)));
        drain();

        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
